@@ design/tpr_pkg.sv @@
// Shared types and constants for the tach period to rpm converter.
package tpr_pkg;

   localparam int TIME_W = 16;
   localparam int RPM_W = 16;
   localparam int DIVIDEND_W = 26;
   localparam int CNT_W = $clog2(DIVIDEND_W);

   localparam logic [DIVIDEND_W-1:0] TICKS_PER_MINUTE = DIVIDEND_W'(60000000);
   localparam logic [RPM_W-1:0] RPM_MAX = {RPM_W{1'b1}};
   localparam logic [TIME_W-1:0] SAT_LIMIT = TIME_W'(60000000 / (1 << RPM_W));

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_PUSH
   } state_type;

endpackage

@@ design/tpr_serial_div.sv @@
// Bit-serial restoring divider of the ticks-per-minute constant by the period.
module tpr_serial_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tpr_pkg::TIME_W-1:0]  divisor,
   output logic                        done,
   output logic [tpr_pkg::RPM_W-1:0]   quotient
);
   import tpr_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [TIME_W-1:0]     div_ff, div_in;
   logic [TIME_W-1:0]     rem_ff, rem_in;
   logic [RPM_W-1:0]      quo_ff, quo_in;
   logic [TIME_W:0]       shifted;
   logic [TIME_W:0]       diff;
   logic                  ge;

   assign shifted = {rem_ff, dvd_ff[DIVIDEND_W-1]};
   assign diff = shifted - {1'b0, div_ff};
   assign ge = shifted >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(DIVIDEND_W - 1);
         dvd_in = TICKS_PER_MINUTE;
         div_in = divisor;
         rem_in = '0;
         quo_in = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         rem_in = ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
         quo_in = {quo_ff[RPM_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

@@ design/tach_period_to_rpm.sv @@
// Top level: converts tach capture timestamps into a held rpm value.
// A capture that needs a division gives its result through the 26-step bit-serial
// divider and then the response register; other captures go straight to the response register.
// One capture is worked on at a time, so a new transfer is taken only once the last
// result has gone into the response register, which a stalled receiver can hold off.
// Synchronous reset clears the held rpm, the stored capture and the first-capture flag.
module tach_period_to_rpm (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [tpr_pkg::TIME_W-1:0]  req_tdata,   // [15:0] capture_time
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [tpr_pkg::RPM_W-1:0]   rsp_tdata,   // [15:0] rpm
   output logic                        rsp_tuser    // [0] updated
);
   import tpr_pkg::*;

   state_type          state_ff, state_in;
   logic               seen_ff, seen_in;
   logic [TIME_W-1:0]  last_ff, last_in;
   logic [RPM_W-1:0]   speed_ff, speed_in;
   logic               upd_ff, upd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RPM_W-1:0]   rsp_rpm_ff, rsp_rpm_in;
   logic               rsp_upd_ff, rsp_upd_in;
   logic [TIME_W-1:0]  period;
   logic               div_start;
   logic               div_done;
   logic [RPM_W-1:0]   div_quotient;

   assign period = req_tdata - last_ff;

   tpr_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (period),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      seen_in = seen_ff;
      last_in = last_ff;
      speed_in = speed_ff;
      upd_in = upd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_rpm_in = rsp_rpm_ff;
      rsp_upd_in = rsp_upd_ff;
      req_tready = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               seen_in = 1'b1;
               last_in = req_tdata;
               upd_in = 1'b0;
               state_in = ST_PUSH;
               if (seen_ff && period != '0) begin
                  upd_in = 1'b1;
                  if (period <= SAT_LIMIT) begin
                     speed_in = RPM_MAX;
                  end else begin
                     div_start = 1'b1;
                     state_in = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               speed_in = div_quotient;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_rpm_in = speed_ff;
               rsp_upd_in = upd_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff <= 1'b0;
         last_ff <= '0;
         speed_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seen_ff <= seen_in;
         last_ff <= last_in;
         speed_ff <= speed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      upd_ff <= upd_in;
      rsp_rpm_ff <= rsp_rpm_in;
      rsp_upd_ff <= rsp_upd_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_rpm_ff;
   assign rsp_tuser = rsp_upd_ff;

endmodule

@@ tb/tach_period_to_rpm_tb.sv @@
// Self-checking testbench for the tach period to rpm converter.
`timescale 1ns / 100ps

module tach_period_to_rpm_tb;
   import tpr_pkg::*;

   localparam int unsigned TICKS_PER_MIN = 60000000;
   localparam int unsigned RPM_CEILING = 65535;
   localparam int RANDOM_CAPTURES = 1430;
   localparam int MAX_CYCLES = 600000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [RPM_W-1:0] rpm;
      logic             updated;
   } speed_rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] capture;
      logic              typed;
      logic [RPM_W-1:0]  rpm;
      logic              updated;
   } capture_row_type;

   localparam int DIRECTED_ROWS = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [TIME_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RPM_W-1:0] rsp_tdata;
   logic rsp_tuser;

   logic [TIME_W-1:0] tach_last;
   logic tach_seen;
   logic [RPM_W-1:0] rpm_held;
   speed_rsp_type pending_speeds[$];

   int error_count = 0;
   int cycle_count = 0;
   int captures_sent = 0;
   int speeds_checked = 0;
   int recomputed_count = 0;
   int saturated_count = 0;
   int held_count = 0;

   capture_row_type directed_rows [DIRECTED_ROWS] = '{
      '{16'h0000, 1'b1, 16'd0,     1'b0},
      '{16'h0000, 1'b1, 16'd0,     1'b0},
      '{16'h0001, 1'b1, 16'd65535, 1'b1},
      '{16'hFFFF, 1'b0, 16'd0,     1'b0},
      '{16'h0000, 1'b1, 16'd65535, 1'b1},
      '{16'h0000, 1'b1, 16'd65535, 1'b0},
      '{16'h0393, 1'b0, 16'd0,     1'b0},
      '{16'h0727, 1'b0, 16'd0,     1'b0},
      '{16'h0726, 1'b0, 16'd0,     1'b0},
      '{16'h0726, 1'b0, 16'd0,     1'b0},
      '{16'hAAAA, 1'b0, 16'd0,     1'b0},
      '{16'h5555, 1'b0, 16'd0,     1'b0},
      '{16'hFF00, 1'b0, 16'd0,     1'b0},
      '{16'h00FF, 1'b1, 16'd65535, 1'b1},
      '{16'h8000, 1'b0, 16'd0,     1'b0},
      '{16'h7FFF, 1'b0, 16'd0,     1'b0},
      '{16'hFC18, 1'b0, 16'd0,     1'b0},
      '{16'h0000, 1'b1, 16'd60000, 1'b1},
      '{16'h3A98, 1'b1, 16'd4000,  1'b1},
      '{16'h3A98, 1'b1, 16'd4000,  1'b0}
   };

   tach_period_to_rpm dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic speed_rsp_type predict_speed(input logic [TIME_W-1:0] capture);
      logic [TIME_W-1:0] period;
      int unsigned quotient;
      speed_rsp_type rsp;
      rsp.updated = 1'b0;
      if (tach_seen) begin
         period = capture - tach_last;
         if (period != '0) begin
            quotient = TICKS_PER_MIN / period;
            if (quotient > RPM_CEILING) begin
               quotient = RPM_CEILING;
            end
            rpm_held = quotient[RPM_W-1:0];
            rsp.updated = 1'b1;
         end
      end else begin
         tach_seen = 1'b1;
      end
      tach_last = capture;
      rsp.rpm = rpm_held;
      return rsp;
   endfunction

   task automatic send_capture(input logic [TIME_W-1:0] capture, input logic typed,
                               input speed_rsp_type typed_rsp);
      speed_rsp_type predicted;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= capture;
      do begin
         @(posedge clock);
      end while (!req_tready);
      predicted = predict_speed(capture);
      pending_speeds.push_back(typed ? typed_rsp : predicted);
      captures_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata <= TIME_W'($urandom);
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic wait_for_all_speeds();
      pause_sender(1);
      while (pending_speeds.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // The receiver switches between stall patterns in turn, chosen by bits 9:8 of the cycle count.
   always @(negedge clock) begin
      case (cycle_count[9:8])
         2'd0: begin
            rsp_tready <= 1'b1;
         end
         2'd1: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         2'd2: begin
            rsp_tready <= ((cycle_count % 23) > 15);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 1) != 0);
         end
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLES) begin
         $display("Timed out after %0d cycles with %0d speeds pending.", cycle_count,
                  pending_speeds.size());
         $display("tach_period_to_rpm_tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      speed_rsp_type expected;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_speeds.size() == 0) begin
            $error("Unexpected transfer: rpm %0d updated %0b", rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            expected = pending_speeds.pop_front();
            speeds_checked++;
            if (rsp_tdata !== expected.rpm) begin
               $error("rpm: expected %0d, actual %0d", expected.rpm, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== expected.updated) begin
               $error("updated: expected %0b, actual %0b", expected.updated, rsp_tuser);
               error_count++;
            end
            if (expected.updated) begin
               recomputed_count++;
               if (expected.rpm == RPM_MAX) begin
                  saturated_count++;
               end
            end else begin
               held_count++;
            end
         end
      end
   end

   initial begin
      logic [TIME_W-1:0] last_capture;
      logic [TIME_W-1:0] delta;
      int pick;
      int burst_left;
      bit steady;
      tach_last = '0;
      tach_seen = 1'b0;
      rpm_held = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_capture(directed_rows[i].capture, directed_rows[i].typed,
                      '{rpm: directed_rows[i].rpm, updated: directed_rows[i].updated});
      end
      last_capture = directed_rows[DIRECTED_ROWS-1].capture;
      wait_for_all_speeds();

      burst_left = 0;
      steady = 1'b0;
      for (int n = 0; n < RANDOM_CAPTURES; n++) begin
         if (n == RANDOM_CAPTURES / 2) begin
            wait_for_all_speeds();
         end
         if (n % 300 == 0) begin
            steady = ~steady;
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            delta = TIME_W'($urandom_range(916, 65535));
         end else if (pick < 60) begin
            delta = TIME_W'($urandom_range(1, 915));
         end else if (pick < 68) begin
            delta = '0;
         end else if (pick < 76) begin
            delta = TIME_W'($urandom_range(905, 925));
         end else if (pick < 84) begin
            delta = TIME_W'($urandom_range(65400, 65535));
         end else begin
            delta = TIME_W'($urandom) - last_capture;
         end
         last_capture = last_capture + delta;
         send_capture(last_capture, 1'b0, '0);
         if (!steady) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 8);
               pause_sender($urandom_range(1, 35));
            end else begin
               burst_left--;
            end
         end
      end

      wait_for_all_speeds();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_speeds.size() != 0) begin
         $error("%0d expected speeds never arrived", pending_speeds.size());
         error_count++;
      end

      $display("Sent %0d captures and checked %0d speeds.", captures_sent, speeds_checked);
      $display("Recomputed %0d (saturated %0d), held %0d on first or zero-period captures.",
               recomputed_count, saturated_count, held_count);
      if (error_count == 0) begin
         $display("tach_period_to_rpm_tb: PASS");
      end else begin
         $display("tach_period_to_rpm_tb: FAIL");
      end
      $finish;
   end

endmodule
